[hw/rtl/bfbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbp_pkg: shared types, constants and helpers for the best-fit buffer pool
// Table geometry, mode and status codes, the entry record that moves along
// the cell chain, and width conversion helpers.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int CAPACITY  = 16;
  localparam int SIZE_BITS = 32;
  localparam int ID_BITS   = 32;

  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam int FIELD_W   = 32;
  localparam int SLOT_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_ACQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_FIT     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RESIZED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NEW     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_UNLOCK  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_FREED   = 3'd6;
  localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd7;

  typedef struct packed {
    logic [ID_BITS-1:0]   ident;
    logic [SIZE_BITS-1:0] bytes;
    logic                 held;
  } entry_t;

  // chain control: shift toward head, and/or load one cell from the bus
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] load_idx;
    entry_t           bus;
  } ctl_t;

  function automatic logic [SIZE_BITS-1:0] size_in(input logic [FIELD_W-1:0] x);
    logic [SIZE_BITS+FIELD_W-1:0] t;
    t = {{SIZE_BITS{1'b0}}, x};
    return t[SIZE_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] size_out(input logic [SIZE_BITS-1:0] x);
    logic [SIZE_BITS+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, x};
    return t[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] id_out(input logic [ID_BITS-1:0] x);
    logic [ID_BITS+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, x};
    return t[FIELD_W-1:0];
  endfunction

  // compare a stored id with a port id, both zero-extended
  function automatic logic id_eq(input logic [ID_BITS-1:0] a,
                                 input logic [FIELD_W-1:0] b);
    logic [ID_BITS+FIELD_W-1:0] ta;
    logic [ID_BITS+FIELD_W-1:0] tb;
    ta = {{FIELD_W{1'b0}}, a};
    tb = {{ID_BITS{1'b0}}, b};
    return ta == tb;
  endfunction

  function automatic logic [SLOT_W-1:0] idx_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, i};
    return t[SLOT_W-1:0];
  endfunction

endpackage

[hw/rtl/bfbp_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbp_cell: one table entry of the buffer pool chain
// Holds id, size and lock mark. Takes its upstream neighbor on a shift, or
// the shared bus when it is the addressed load position.
// ----------------------------------------------------------------------------
module bfbp_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfbp_pkg::ctl_t             ctl,
  input  logic [bfbp_pkg::IDX_W-1:0] pos,
  input  bfbp_pkg::entry_t           nb,
  output bfbp_pkg::entry_t           q
);
  import bfbp_pkg::*;

  logic [ID_BITS-1:0]   ident_r;
  logic [SIZE_BITS-1:0] bytes_r;
  logic                 held_r;
  logic                 sel;

  assign sel = ctl.load && (ctl.load_idx == pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (sel) begin
      held_r <= ctl.bus.held;
    end else if (ctl.shift) begin
      held_r <= nb.held;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (sel) begin
      ident_r <= ctl.bus.ident;
      bytes_r <= ctl.bus.bytes;
    end else if (ctl.shift) begin
      ident_r <= nb.ident;
      bytes_r <= nb.bytes;
    end
  end

  assign q.ident = ident_r;
  assign q.bytes = bytes_r;
  assign q.held  = held_r;

endmodule

[hw/rtl/bfbp_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbp_chain: row of table cells
// Cells shift one place toward the head per step; cell 0 is the head seen
// by the controller. A load writes one addressed cell from the bus.
// ----------------------------------------------------------------------------
module bfbp_chain (
  input  logic             clk,
  input  logic             rst_n,
  input  bfbp_pkg::ctl_t   ctl,
  output bfbp_pkg::entry_t head
);
  import bfbp_pkg::*;

  entry_t q  [CAPACITY];
  entry_t nb [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_tail
      assign nb[g] = '0;
    end else begin : g_link
      assign nb[g] = q[g+1];
    end

    bfbp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .pos   (IDX_W'(g)),
      .nb    (nb[g]),
      .q     (q[g])
    );
  end

  assign head = q[0];

endmodule

[hw/rtl/best_fit_buffer_pool.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_buffer_pool: best-fit cache of buffer entries
// Keeps an ordered table of buffers (id, size, lock). Acquire, release by
// id, and clear of all unlocked entries with one freed word per entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_t*: in_tuser carries the mode (acquire, release,
//   clear); in_tdata carries the request size and the release id. One input
//   word is taken at a time; in_tready is high only while the block is idle.
//   Result words leave on out_t*: out_tuser is the status, out_tdata holds
//   id, slot and size, out_tlast marks the final word of an input word.
//   Acquire and release give one word, clear gives one freed word per
//   unlocked entry and a final done word. Mode 3 is dropped silently.
// Sequence (the table holds at most 16 entries):
//   Acquire / release: the table rotates once through the head cell, the
//   end of the pass is seen, then the finish step loads the output
//   register with the result word and the block returns to idle to take
//   the next input.
//   Clear: each entry passes the head in turn (a freed word for each
//   unlocked one), the pass ends, then the done word follows.
// Stall: while out_tready refuses a held output word, the finish step and
//   every clear step wait; the output register keeps its word. Nothing is lost.
// Reset: rst_n (synchronous, active low) empties the table, clears all lock
//   marks and restarts ids at 1.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] request_size, [63:32] release_id
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] handle_id, [35:32] slot,
                                  // [67:36] granted_size, [71:68] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);
  import bfbp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CLR  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [FIELD_W-1:0]   rid_r, rid_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;     // original position at head
  logic [CNT_W-1:0]     len_r, len_nxt;     // live length during clear
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [ID_BITS-1:0]   next_id_r, next_id_nxt;

  // best fit candidate (also the id hit for release)
  logic                 fit_found_r, fit_found_nxt;
  logic [IDX_W-1:0]     fit_at_r, fit_at_nxt;
  logic [SIZE_BITS-1:0] fit_sz_r, fit_sz_nxt;
  logic [ID_BITS-1:0]   fit_id_r, fit_id_nxt;
  // largest smaller candidate
  logic                 small_found_r, small_found_nxt;
  logic [IDX_W-1:0]     small_at_r, small_at_nxt;
  logic [SIZE_BITS-1:0] small_sz_r, small_sz_nxt;
  logic [ID_BITS-1:0]   small_id_r, small_id_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [FIELD_W-1:0]   out_id_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [FIELD_W-1:0]   out_size_r;
  logic                 out_last_r;

  logic                 emit;
  logic [STATUS_W-1:0]  e_status;
  logic [FIELD_W-1:0]   e_id;
  logic [SLOT_W-1:0]    e_slot;
  logic [FIELD_W-1:0]   e_size;
  logic                 e_last;

  ctl_t                 ctl;
  entry_t               head;
  logic                 out_free;
  logic [IDX_W-1:0]     cur_idx;
  logic [CNT_W-1:0]     scan_tail;
  logic [CNT_W-1:0]     clr_tail;

  bfbp_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (head)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cur_idx   = cnt_r[IDX_W-1:0];
  assign scan_tail = total_r - CNT_W'(1);
  assign clr_tail  = len_r - CNT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    req_nxt         = req_r;
    rid_nxt         = rid_r;
    cnt_nxt         = cnt_r;
    len_nxt         = len_r;
    total_nxt       = total_r;
    next_id_nxt     = next_id_r;
    fit_found_nxt   = fit_found_r;
    fit_at_nxt      = fit_at_r;
    fit_sz_nxt      = fit_sz_r;
    fit_id_nxt      = fit_id_r;
    small_found_nxt = small_found_r;
    small_at_nxt    = small_at_r;
    small_sz_nxt    = small_sz_r;
    small_id_nxt    = small_id_r;
    ctl             = '0;
    emit            = 1'b0;
    e_status        = STAT_FIT;
    e_id            = '0;
    e_slot          = '0;
    e_size          = '0;
    e_last          = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt        = in_tuser;
          req_nxt         = size_in(in_tdata[31:0]);
          rid_nxt         = in_tdata[63:32];
          cnt_nxt         = '0;
          len_nxt         = total_r;
          fit_found_nxt   = 1'b0;
          small_found_nxt = 1'b0;
          small_sz_nxt    = '0;
          unique case (in_tuser) inside
            MODE_ACQ, MODE_REL: state_nxt = S_SCAN;
            MODE_CLR:           state_nxt = S_CLR;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end

      // rotate the table once past the head; head goes back to the tail
      S_SCAN: begin
        if (cnt_r == total_r) begin
          state_nxt = S_FIN;
        end else begin
          ctl.shift    = 1'b1;
          ctl.load     = 1'b1;
          ctl.load_idx = scan_tail[IDX_W-1:0];
          ctl.bus      = head;
          cnt_nxt      = cnt_r + CNT_W'(1);
          if (mode_r == MODE_ACQ) begin
            if (!head.held && head.bytes > small_sz_r && head.bytes <= req_r) begin
              small_found_nxt = 1'b1;
              small_at_nxt    = cur_idx;
              small_sz_nxt    = head.bytes;
              small_id_nxt    = head.ident;
            end
            if (!head.held && head.bytes >= req_r &&
                (!fit_found_r || head.bytes < fit_sz_r)) begin
              fit_found_nxt = 1'b1;
              fit_at_nxt    = cur_idx;
              fit_sz_nxt    = head.bytes;
              fit_id_nxt    = head.ident;
            end
          end else if (!fit_found_r && id_eq(head.ident, rid_r)) begin
            fit_found_nxt = 1'b1;
            fit_at_nxt    = cur_idx;
            fit_sz_nxt    = head.bytes;
            fit_id_nxt    = head.ident;
          end
        end
      end

      // stable compaction: locked heads rejoin at the live tail
      S_CLR: begin
        if (cnt_r == total_r) begin
          state_nxt = S_FIN;
        end else if (out_free) begin
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          if (head.held) begin
            ctl.load     = 1'b1;
            ctl.load_idx = clr_tail[IDX_W-1:0];
            ctl.bus      = head;
          end else begin
            len_nxt  = clr_tail;
            emit     = 1'b1;
            e_status = STAT_FREED;
            e_id     = id_out(head.ident);
            e_slot   = idx_slot(cur_idx);
            e_size   = size_out(head.bytes);
            e_last   = 1'b0;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          unique case (mode_r)
            MODE_ACQ: begin
              if (fit_found_r) begin
                ctl.load     = 1'b1;
                ctl.load_idx = fit_at_r;
                ctl.bus      = '{ident: fit_id_r, bytes: fit_sz_r, held: 1'b1};
                e_status     = STAT_FIT;
                e_id         = id_out(fit_id_r);
                e_slot       = idx_slot(fit_at_r);
                e_size       = size_out(fit_sz_r);
              end else if (small_found_r) begin
                ctl.load     = 1'b1;
                ctl.load_idx = small_at_r;
                ctl.bus      = '{ident: small_id_r, bytes: req_r, held: 1'b1};
                e_status     = STAT_RESIZED;
                e_id         = id_out(small_id_r);
                e_slot       = idx_slot(small_at_r);
                e_size       = size_out(req_r);
              end else if (total_r < CNT_W'(CAPACITY)) begin
                ctl.load     = 1'b1;
                ctl.load_idx = total_r[IDX_W-1:0];
                ctl.bus      = '{ident: next_id_r, bytes: req_r, held: 1'b1};
                total_nxt    = total_r + CNT_W'(1);
                next_id_nxt  = next_id_r + ID_BITS'(1);
                e_status     = STAT_NEW;
                e_id         = id_out(next_id_r);
                e_slot       = idx_slot(total_r[IDX_W-1:0]);
                e_size       = size_out(req_r);
              end else begin
                e_status     = STAT_FULL;
              end
            end
            MODE_REL: begin
              e_id = rid_r;
              if (fit_found_r) begin
                ctl.load     = 1'b1;
                ctl.load_idx = fit_at_r;
                ctl.bus      = '{ident: fit_id_r, bytes: fit_sz_r, held: 1'b0};
                e_status     = STAT_UNLOCK;
                e_slot       = idx_slot(fit_at_r);
                e_size       = size_out(fit_sz_r);
              end else begin
                e_status     = STAT_UNKNOWN;
              end
            end
            MODE_CLR: begin
              total_nxt = len_r;
              e_status  = STAT_DONE;
              e_size    = FIELD_W'(len_r);
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      next_id_r   <= ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      next_id_r <= next_id_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed (loaded on acceptance)
  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    req_r         <= req_nxt;
    rid_r         <= rid_nxt;
    cnt_r         <= cnt_nxt;
    len_r         <= len_nxt;
    fit_found_r   <= fit_found_nxt;
    fit_at_r      <= fit_at_nxt;
    fit_sz_r      <= fit_sz_nxt;
    fit_id_r      <= fit_id_nxt;
    small_found_r <= small_found_nxt;
    small_at_r    <= small_at_nxt;
    small_sz_r    <= small_sz_nxt;
    small_id_r    <= small_id_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_id_r     <= e_id;
      out_slot_r   <= e_slot;
      out_size_r   <= e_size;
      out_last_r   <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_size_r, out_slot_r, out_id_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for best_fit_buffer_pool
// Drives acquire, release and clear words into the pool and tracks its own
// copy of the buffer table to predict every result word. A directed opening
// hits the edge cases: zero and all-ones sizes, ties, resize, unknown and
// repeated release, empty clear and the dropped mode. Random phases with
// sender gaps and receiver stalls follow. Result words are checked in order,
// field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bfbp_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASE_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 40;   // longer than one full-table scan

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;  // unused code, dropped

  // one result word as the bench predicts it
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [31:0]         handle;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         gsize;
    logic                last;
  } pool_word_t;

  // --------------------------------------------------------------------------
  // Table tracker: mirrors the pool state and queues the words it must emit.
  // --------------------------------------------------------------------------
  class pool_tracker;
    logic [31:0] ident [CAPACITY];
    logic [31:0] bytes [CAPACITY];
    bit          held  [CAPACITY];
    int          total;
    logic [31:0] next_id;
    pool_word_t  expected_words [$];
    int          errors;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        ident[i] = '0;
        bytes[i] = '0;
        held[i]  = 1'b0;
      end
      total   = 0;
      next_id = 32'd1;
      errors  = 0;
    endfunction

    function void push(logic [STATUS_W-1:0] st, logic [31:0] h, int s,
                       logic [31:0] g, logic l);
      pool_word_t w;
      w.status = st;
      w.handle = h;
      w.slot   = SLOT_W'(s);
      w.gsize  = g;
      w.last   = l;
      expected_words.push_back(w);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // id of some table entry, for releases that should hit
    function logic [31:0] pick_id();
      if (total == 0) return $urandom;
      return ident[$urandom_range(total - 1)];
    endfunction

    // update the table for one accepted input word and queue its results
    function void note_request(logic [MODE_W-1:0] mode, logic [31:0] req,
                               logic [31:0] rid);
      bit          fit_found;
      bit          small_found;
      int          fit_at;
      int          small_at;
      int          keep;
      logic [31:0] fit_sz;
      logic [31:0] small_sz;
      fit_found   = 1'b0;
      small_found = 1'b0;
      fit_at      = 0;
      small_at    = 0;
      fit_sz      = '0;
      small_sz    = '0;
      keep        = 0;
      case (mode)
        MODE_ACQ: begin
          for (int i = 0; i < total; i++) begin
            if (!held[i]) begin
              if (bytes[i] > small_sz && bytes[i] <= req) begin
                small_sz    = bytes[i];
                small_at    = i;
                small_found = 1'b1;
              end
              if (bytes[i] >= req && (!fit_found || bytes[i] < fit_sz)) begin
                fit_sz    = bytes[i];
                fit_at    = i;
                fit_found = 1'b1;
              end
            end
          end
          if (fit_found) begin
            held[fit_at] = 1'b1;
            push(STAT_FIT, ident[fit_at], fit_at, bytes[fit_at], 1'b1);
          end else if (small_found) begin
            bytes[small_at] = req;
            held[small_at]  = 1'b1;
            push(STAT_RESIZED, ident[small_at], small_at, req, 1'b1);
          end else if (total < CAPACITY) begin
            ident[total] = next_id;
            bytes[total] = req;
            held[total]  = 1'b1;
            push(STAT_NEW, next_id, total, req, 1'b1);
            total++;
            next_id = next_id + 32'd1;
          end else begin
            push(STAT_FULL, '0, 0, '0, 1'b1);
          end
        end
        MODE_REL: begin
          for (int i = 0; i < total; i++) begin
            if (!fit_found && ident[i] == rid) begin
              held[i]   = 1'b0;
              fit_found = 1'b1;
              push(STAT_UNLOCK, rid, i, bytes[i], 1'b1);
            end
          end
          if (!fit_found) push(STAT_UNKNOWN, rid, 0, '0, 1'b1);
        end
        MODE_CLR: begin
          // stable compaction; freed words carry the slot before removal
          for (int i = 0; i < total; i++) begin
            if (!held[i]) begin
              push(STAT_FREED, ident[i], i, bytes[i], 1'b0);
            end else begin
              ident[keep] = ident[i];
              bytes[keep] = bytes[i];
              held[keep]  = 1'b1;
              keep++;
            end
          end
          for (int i = keep; i < CAPACITY; i++) held[i] = 1'b0;
          total = keep;
          push(STAT_DONE, '0, 0, 32'(keep), 1'b1);
        end
        default: ;  // mode 3 is dropped by the pool
      endcase
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(logic [2:0] st, logic [71:0] data, logic l);
      pool_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word status %0d data %h", st, data));
        return;
      end
      w = expected_words.pop_front();
      if (st != w.status)
        report($sformatf("status %0d, want %0d", st, w.status));
      if (data[31:0] != w.handle)
        report($sformatf("handle_id %h, want %h", data[31:0], w.handle));
      if (data[35:32] != w.slot)
        report($sformatf("slot %0d, want %0d", data[35:32], w.slot));
      if (data[67:36] != w.gsize)
        report($sformatf("granted_size %h, want %h", data[67:36], w.gsize));
      if (data[71:68] != 4'd0)
        report($sformatf("pad bits %h, want 0", data[71:68]));
      if (l != w.last)
        report($sformatf("tlast %0d, want %0d", l, w.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] request_size, [63:32] release_id
  logic [1:0]  in_tuser   = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // [31:0] handle_id, [35:32] slot,
                                  // [67:36] granted_size, [71:68] zero
  logic [2:0]  out_tuser;         // [2:0] status
  logic        out_tlast;

  int          idle_pct  = 0;     // sender gap chance per cycle, percent
  int          stall_pct = 0;     // receiver stall chance per cycle, percent
  int          cycles    = 0;
  pool_tracker tracker   = new();

  always #6 clk = ~clk;

  best_fit_buffer_pool dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Receiver: ready toggles at the falling edge, one decision per cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor: sample at the rising edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_word(out_tuser, out_tdata, out_tlast);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Present one word, with random gaps in front; valid stays high across
  // back-to-back words so it is never dropped and raised in the same step.
  task automatic send_word(input logic [1:0] mode, input logic [31:0] req,
                           input logic [31:0] rid);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {rid, req};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(mode, req, rid);
  endtask

  // Sizes: mostly a small set of multiples so fits and resizes collide,
  // plus zero, all ones and full-width noise.
  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return 32'd0;
    if (r < 14) return 32'hFFFF_FFFF;
    if (r < 24) return $urandom;
    return 32'($urandom_range(1, 12) * 32);
  endfunction

  // One random word; counted is low for the dropped mode.
  task automatic random_word(input int acq_pct, output bit counted);
    int          r;
    logic [31:0] rid;
    r       = $urandom_range(99);
    counted = 1'b1;
    if (r < acq_pct) begin
      send_word(MODE_ACQ, pick_size(), $urandom);
    end else if (r < 90) begin
      rid = ($urandom_range(99) < 85) ? tracker.pick_id() : 32'($urandom);
      send_word(MODE_REL, $urandom, rid);
    end else if (r < 96) begin
      send_word(MODE_CLR, $urandom, $urandom);
    end else begin
      send_word(MODE_NONE, $urandom, $urandom);
      counted = 1'b0;
    end
  endtask

  initial begin
    int sender_gap [4];
    int rx_stall   [4];
    int acq_weight [4];
    int done;
    bit counted;
    sender_gap = '{0, 71, 0, 23};
    rx_stall   = '{0, 0, 71, 23};
    acq_weight = '{80, 55, 50, 55};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening, no gaps or stalls.
    send_word(MODE_ACQ, 32'd0, 32'hFFFF_FFFF);         // new, zero size
    send_word(MODE_ACQ, 32'hFFFF_FFFF, 32'd0);         // new, all ones
    send_word(MODE_ACQ, 32'd100, $urandom);
    send_word(MODE_ACQ, 32'd100, $urandom);
    send_word(MODE_REL, $urandom, 32'd2);
    send_word(MODE_REL, $urandom, 32'd2);              // already unlocked
    send_word(MODE_ACQ, 32'hFFFF_FFFF, $urandom);      // all-ones entry fits
    send_word(MODE_REL, $urandom, 32'd3);
    send_word(MODE_REL, $urandom, 32'd4);
    send_word(MODE_ACQ, 32'd50, $urandom);             // tie, earliest wins
    send_word(MODE_ACQ, 32'd200, $urandom);            // resize smaller entry
    send_word(MODE_REL, $urandom, 32'd0);              // unknown id
    send_word(MODE_REL, $urandom, 32'hFFFF_FFFF);      // unknown id
    send_word(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // dropped mode
    send_word(MODE_CLR, $urandom, $urandom);           // nothing to free
    send_word(MODE_REL, $urandom, 32'd1);
    send_word(MODE_REL, $urandom, 32'd3);
    send_word(MODE_CLR, $urandom, $urandom);           // frees slots 0 and 2

    // Random phases; the first is acquire-heavy to drive the table full.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = sender_gap[p];
      stall_pct = rx_stall[p];
      if (p == 2) begin
        // hold the sender off until the pool has drained completely
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_word(acq_weight[p], counted);
        if (counted) done++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
